@@ hdl/pta_pkg.sv @@
// Shared constants, types and tables for the pose transform accumulator.
package pta_pkg;

    // Fixed-point format of matrix elements and angles
    localparam int FRACTION_BITS = 16;
    localparam int CORDIC_STEPS  = 18;

    // Field widths
    localparam int ELEM_W  = 32;
    localparam int ANGLE_W = 19;
    localparam int THR_W   = 16;

    // CORDIC datapath widths: x/y hold up to about 2^33, z (Q30) up to about 2^33
    localparam int CW     = 36;
    localparam int ZW     = 35;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] ROUND_Q30 = ZW'(64'sd1 <<< (29 - FRACTION_BITS));
    localparam logic signed [ZW-1:0] PI_F =
        ZW'((64'sd3373259426 + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS));

    // Operation codes
    typedef enum logic [2:0] {
        OP_IDENTITY    = 3'd0,
        OP_WR_OPERAND  = 3'd1,
        OP_MULTIPLY    = 3'd2,
        OP_WR_HELD     = 3'd3,
        OP_QUERY       = 3'd4
    } t_op;

    // Register word indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;

    // CORDIC status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    // Arctangent of 2^-i in Q30
    function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            default: v = 31'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

@@ hdl/pta_cordic.sv @@
// Iterative CORDIC vectoring unit computing atan2(y, x) in fixed point.
module pta_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pta_pkg::CW-1:0]          i_y,
    input  logic signed [pta_pkg::CW-1:0]          i_x,
    output pta_pkg::t_cordic_sts                   o_sts,
    output logic signed [pta_pkg::ANGLE_W-1:0]     o_angle
);

    logic                                  r_busy;
    logic                                  r_done;
    logic                                  r_zero;
    logic [pta_pkg::STEP_W-1:0]            r_i;
    logic signed [pta_pkg::CW-1:0]         r_x;
    logic signed [pta_pkg::CW-1:0]         r_y;
    logic signed [pta_pkg::ZW-1:0]         r_z;
    logic signed [pta_pkg::CW-1:0]         n_xs;
    logic signed [pta_pkg::CW-1:0]         n_ys;
    logic signed [pta_pkg::ZW-1:0]         n_atan;
    logic signed [pta_pkg::ZW-1:0]         n_round;
    logic signed [pta_pkg::ZW-1:0]         n_clamp;

    localparam logic [pta_pkg::STEP_W-1:0] STEP_LAST =
        pta_pkg::STEP_W'(pta_pkg::CORDIC_STEPS - 1);

    // Shifted terms for the current micro-rotation
    assign n_xs   = r_x >>> r_i;
    assign n_ys   = r_y >>> r_i;
    assign n_atan = pta_pkg::ZW'($signed({1'b0, pta_pkg::atan_q30(r_i)}));

    // Round to the output format and clamp to [-pi, +pi]
    always_comb begin
        n_round = (r_z + pta_pkg::ROUND_Q30) >>> (30 - pta_pkg::FRACTION_BITS);
        if (n_round > pta_pkg::PI_F) begin
            n_clamp = pta_pkg::PI_F;
        end else if (n_round < -pta_pkg::PI_F) begin
            n_clamp = -pta_pkg::PI_F;
        end else begin
            n_clamp = n_round;
        end
    end

    assign o_angle   = r_zero ? '0 : n_clamp[pta_pkg::ANGLE_W-1:0];
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

    // Load, fold into the right half plane, then rotate one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? pta_pkg::PI_Q30 : -pta_pkg::PI_Q30;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_atan;
                end else begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_atan;
                end
                r_i <= r_i + 1'b1;
                if (r_i == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Done never coincides with an iteration in flight
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> !o_sts.busy) else $error("cordic done while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_sts.done) |-> $past(o_sts.busy)) else $error("cordic done without run");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> (o_angle <= pta_pkg::ANGLE_W'(pta_pkg::PI_F)) &&
                       (o_angle >= -pta_pkg::ANGLE_W'(pta_pkg::PI_F)))
        else $error("cordic angle out of range");

endmodule

@@ hdl/pose_transform_accumulator.sv @@
// Top level: 4x4 transform store, shared MAC/sqrt sequencer and angle query.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready    | operation, row, column, element_value
//  output   | o_out_valid / i_out_ready  | roll, pitch, yaw angles, singular flag
//  config   | psel/penable/pwrite/pready | singular_threshold at word 0
//
//  Element writes and identity complete on acceptance; multiply runs 64
//  multiply-adds on the single 32x32 multiplier through a product register,
//  then copies the result into the held matrix. A query squares m00 and m10,
//  forms a 32-bit bit-serial square root, then makes 2 CORDIC runs on the
//  singular branch, 3 otherwise (start, 18 steps, handoff), and loads the result.
//  o_in_ready is high only while the sequencer is idle; a finished query
//  waits in the output register, and the block stalls only if a second
//  result is ready while the first is still untaken.
//  Reset is synchronous, active low, and loads the identity matrix.
module pose_transform_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input transaction
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [2:0]                            i_operation,
    input  logic [1:0]                            i_row,
    input  logic [1:0]                            i_column,
    input  logic signed [pta_pkg::ELEM_W-1:0]     i_element_value,
    // Result transaction
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [pta_pkg::ANGLE_W-1:0]    o_roll_angle,
    output logic signed [pta_pkg::ANGLE_W-1:0]    o_pitch_angle,
    output logic signed [pta_pkg::ANGLE_W-1:0]    o_yaw_angle,
    output logic                                  o_singular_flag,
    // Configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [1:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_COPY, S_SQ0, S_SQ1, S_SQ2, S_SQRT,
        S_PITCH, S_ROLL, S_YAW, S_DONE
    } t_state;

    localparam int ACC_W = 50;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [pta_pkg::ELEM_W-1:0] ONE =
        pta_pkg::ELEM_W'(64'sd1 <<< pta_pkg::FRACTION_BITS);

    t_state                                  r_state;
    logic signed [pta_pkg::ELEM_W-1:0]       r_held [16];
    logic signed [pta_pkg::ELEM_W-1:0]       r_oper [16];
    logic signed [pta_pkg::ELEM_W-1:0]       r_prodm [16];
    logic [pta_pkg::THR_W-1:0]               r_thr;
    logic [6:0]                              r_cnt;
    logic [5:0]                              r_tidx;
    logic signed [63:0]                      r_prod;
    logic signed [ACC_W-1:0]                 r_acc;
    logic [63:0]                             r_sq;
    logic [63:0]                             r_res;
    logic [63:0]                             r_bit;
    logic                                    r_sing;
    logic                                    r_cstart;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_roll;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_pitch;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_yaw;
    logic                                    r_out_valid;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_out_roll;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_out_pitch;
    logic signed [pta_pkg::ANGLE_W-1:0]      r_out_yaw;
    logic                                    r_out_sing;

    logic signed [pta_pkg::ELEM_W-1:0]       n_mul_a;
    logic signed [pta_pkg::ELEM_W-1:0]       n_mul_b;
    logic signed [63:0]                      n_mul;
    logic signed [ACC_W-1:0]                 n_term;
    logic signed [ACC_W-1:0]                 n_sum;
    logic signed [pta_pkg::ELEM_W-1:0]       n_sat;
    logic [63:0]                             n_trial;
    logic [31:0]                             n_sy;
    logic signed [pta_pkg::CW-1:0]           n_cy;
    logic signed [pta_pkg::CW-1:0]           n_cx;
    logic                                    n_accept;
    logic                                    n_cfg_wr;
    pta_pkg::t_cordic_sts                    n_csts;
    logic signed [pta_pkg::ANGLE_W-1:0]      n_angle;

    // Handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;
    assign pready     = 1'b1;
    assign n_cfg_wr   = psel && penable && pwrite && (paddr == pta_pkg::REG_THRESHOLD);
    assign prdata     = (paddr == pta_pkg::REG_THRESHOLD) ? {16'd0, r_thr} : 32'd0;

    assign o_out_valid     = r_out_valid;
    assign o_roll_angle    = r_out_roll;
    assign o_pitch_angle   = r_out_pitch;
    assign o_yaw_angle     = r_out_yaw;
    assign o_singular_flag = r_out_sing;

    // Select multiplier operands: matrix terms, or squares of m00 and m10
    always_comb begin
        case (r_state)
            S_SQ0: begin
                n_mul_a = r_held[0];
                n_mul_b = r_held[0];
            end
            S_SQ1: begin
                n_mul_a = r_held[4];
                n_mul_b = r_held[4];
            end
            default: begin
                n_mul_a = r_held[{r_cnt[5:4], r_cnt[1:0]}];
                n_mul_b = r_oper[{r_cnt[1:0], r_cnt[3:2]}];
            end
        endcase
    end
    assign n_mul = n_mul_a * n_mul_b;

    // Accumulate the truncated product and saturate the dot product
    assign n_term = ACC_W'(r_prod >>> pta_pkg::FRACTION_BITS);
    assign n_sum  = ((r_tidx[1:0] == 2'd0) ? '0 : r_acc) + n_term;
    always_comb begin
        if (n_sum > SAT_MAX) begin
            n_sat = pta_pkg::ELEM_W'(SAT_MAX);
        end else if (n_sum < SAT_MIN) begin
            n_sat = pta_pkg::ELEM_W'(SAT_MIN);
        end else begin
            n_sat = n_sum[pta_pkg::ELEM_W-1:0];
        end
    end

    // Square root trial and its result
    assign n_trial = r_res + r_bit;
    assign n_sy    = r_res[31:0];

    // Route the atan2 arguments for the current angle
    always_comb begin
        case (r_state)
            S_PITCH: begin
                n_cy = -pta_pkg::CW'(r_held[8]);
                n_cx = $signed(pta_pkg::CW'(n_sy));
            end
            S_ROLL: begin
                if (r_sing) begin
                    n_cy = -pta_pkg::CW'(r_held[6]);
                    n_cx = pta_pkg::CW'(r_held[5]);
                end else begin
                    n_cy = pta_pkg::CW'(r_held[9]);
                    n_cx = pta_pkg::CW'(r_held[10]);
                end
            end
            default: begin
                n_cy = pta_pkg::CW'(r_held[4]);
                n_cx = pta_pkg::CW'(r_held[0]);
            end
        endcase
    end

    pta_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_y     (n_cy),
        .i_x     (n_cx),
        .o_sts   (n_csts),
        .o_angle (n_angle)
    );

    // Sequencer, matrix store and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= pta_pkg::THR_W'(1);
            r_cstart    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_held[i] <= ((i / 4) == (i % 4)) ? ONE : '0;
            end
        end else begin
            r_cstart <= 1'b0;
            if (n_cfg_wr) begin
                r_thr <= pwdata[pta_pkg::THR_W-1:0];
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        case (i_operation)
                            pta_pkg::OP_IDENTITY: begin
                                for (int i = 0; i < 16; i++) begin
                                    r_held[i] <= ((i / 4) == (i % 4)) ? ONE : '0;
                                end
                            end
                            pta_pkg::OP_WR_OPERAND: begin
                                r_oper[{i_row, i_column}] <= i_element_value;
                            end
                            pta_pkg::OP_WR_HELD: begin
                                r_held[{i_row, i_column}] <= i_element_value;
                            end
                            pta_pkg::OP_MULTIPLY: begin
                                r_cnt   <= '0;
                                r_state <= S_MAC;
                            end
                            pta_pkg::OP_QUERY: begin
                                r_state <= S_SQ0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MAC: begin
                    // Multiply term cnt while accumulating term cnt-1
                    if (r_cnt < 7'd64) begin
                        r_prod <= n_mul;
                        r_tidx <= r_cnt[5:0];
                    end
                    if (r_cnt != 7'd0) begin
                        r_acc <= n_sum;
                        if (r_tidx[1:0] == 2'd3) begin
                            r_prodm[r_tidx[5:2]] <= n_sat;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd64) begin
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    for (int i = 0; i < 16; i++) begin
                        r_held[i] <= r_prodm[i];
                    end
                    r_state <= S_IDLE;
                end
                S_SQ0: begin
                    r_prod  <= n_mul;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_sq    <= r_prod;
                    r_prod  <= n_mul;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq    <= r_sq + r_prod;
                    r_res   <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // One result bit per cycle
                    if (r_sq >= n_trial) begin
                        r_sq  <= r_sq - n_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd31) begin
                        r_cstart <= 1'b1;
                        r_state  <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    r_sing <= ({16'd0, r_thr} > n_sy);
                    if (n_csts.done) begin
                        r_pitch  <= n_angle;
                        r_cstart <= 1'b1;
                        r_state  <= S_ROLL;
                    end
                end
                S_ROLL: begin
                    if (n_csts.done) begin
                        r_roll <= n_angle;
                        if (r_sing) begin
                            r_yaw   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_cstart <= 1'b1;
                            r_state  <= S_YAW;
                        end
                    end
                end
                S_YAW: begin
                    if (n_csts.done) begin
                        r_yaw   <= n_angle;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_roll  <= r_roll;
                        r_out_pitch <= r_pitch;
                        r_out_yaw   <= r_yaw;
                        r_out_sing  <= r_sing;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The CORDIC unit is never running while the sequencer is idle
    a_idle_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !n_csts.busy) else $error("cordic busy while idle");

    // A singular result always carries zero yaw
    a_sing_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sing) |-> (r_out_yaw == '0)) else $error("yaw not zero");

    // CORDIC completes only inside an angle state
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_csts.done |-> (r_state == S_PITCH) || (r_state == S_ROLL) || (r_state == S_YAW))
        else $error("cordic done outside angle states");

    // A result is loaded only on leaving the done state
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE)) else $error("stray result");

endmodule
